>>> sv/mccp_pkg.sv
// mccp_pkg: shared types, codes and command table for the memory card command parser
package mccp_pkg;

    // command byte meaning no valid command pending
    localparam logic [7:0] CMD_NONE = 8'hFF;

    // per-byte event codes reported on the result channel
    typedef enum logic [2:0] {
        EVT_CMD_ACCEPT = 3'd0,
        EVT_CMD_UNKNOWN = 3'd1,
        EVT_ADDR_BYTE = 3'd2,
        EVT_DUMMY_BYTE = 3'd3,
        EVT_EXTRA_BYTE = 3'd4
    } byte_event_t;

    // masks used to fold the argument into a linear card offset
    localparam logic [31:0] OFS_BYTE_MASK = 32'h0000_007F;
    localparam logic [31:0] OFS_PAGE_MASK = 32'h0000_0300;
    localparam logic [31:0] OFS_SECT_MASK = 32'h7FFF_0000;

    // command table entry
    typedef struct packed {
        logic       hit;
        logic [2:0] addr_bytes;
        logic [2:0] dummy_bytes;
        logic [3:0] cls;
    } cmd_info_t;

    // command table lookup
    function automatic cmd_info_t cmd_lookup(input logic [7:0] code);
        cmd_info_t info;
        info = '0;
        case (code)
            8'h83: info = '{1'b1, 3'd0, 3'd1, 4'h1};
            8'h89: info = '{1'b1, 3'd0, 3'd0, 4'h2};
            8'hF2: info = '{1'b1, 3'd4, 3'd0, 4'h8};
            8'h52: info = '{1'b1, 3'd4, 3'd4, 4'h5};
            8'hF1: info = '{1'b1, 3'd2, 3'd0, 4'h2};
            8'h00: info = '{1'b1, 3'd0, 3'd1, 4'h1};
            8'hF4: info = '{1'b1, 3'd0, 3'd0, 4'h2};
            8'h81: info = '{1'b1, 3'd1, 3'd0, 4'h2};
            8'h85: info = '{1'b1, 3'd0, 3'd1, 4'h1};
            8'h88: info = '{1'b1, 3'd0, 3'd0, 4'h2};
            8'h87: info = '{1'b1, 3'd0, 3'd0, 4'h2};
            default: info = '0;
        endcase
        return info;
    endfunction

    // fold sector, page and byte fields into a linear offset
    function automatic logic [23:0] fold_offset(input logic [31:0] arg);
        logic [31:0] folded;
        folded = (arg & OFS_BYTE_MASK) | ((arg & OFS_PAGE_MASK) >> 1)
               | ((arg & OFS_SECT_MASK) >> 7);
        return folded[23:0];
    endfunction

endpackage

>>> sv/memory_card_command_parser_core.sv
// memory_card_command_parser_core: byte-wise command decoder for the card write path
//
// Input channel (s_valid/s_ready): one host byte per transaction, with
// s_ends_transfer high on the last byte of a write transfer.
// Result channel (m_valid/m_ready): one result per input byte, giving the
// byte's event, ready state, pending command, packed argument, folded card
// offset, extra-area flag and execution class after that byte.
// The result is registered: it appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the result channel is not stalled; the
// decode is a table match and a counter update ahead of a single result register.
// Stall: while a result waits on m_ready, s_ready stays high only if that
// result is taken in the same cycle, so nothing is lost or repeated.
// Reset (aresetn low, synchronous): no command pending, ready state set,
// counters and argument cleared, result register empty.
module memory_card_command_parser_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_data_byte,
    input  logic                    s_ends_transfer,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [2:0]              m_byte_event,
    output logic                    m_command_ready,
    output logic [7:0]              m_command_code,
    output logic [31:0]             m_command_argument,
    output logic [23:0]             m_card_offset,
    output logic                    m_extra_area_flag,
    output logic [3:0]              m_execution_class
);
    import mccp_pkg::*;

    // decoder state
    logic [7:0]  pend_cmd_reg, pend_cmd_next;
    logic        ready_reg, ready_next;
    logic [2:0]  addr_need_reg, addr_need_next;
    logic [2:0]  addr_seen_reg, addr_seen_next;
    logic [2:0]  dummy_need_reg, dummy_need_next;
    logic [2:0]  dummy_seen_reg, dummy_seen_next;
    logic [31:0] arg_reg, arg_next;
    logic [3:0]  cls_reg, cls_next;

    // result register
    logic        out_valid_reg;
    byte_event_t out_event_reg;
    logic        out_ready_reg;
    logic [7:0]  out_cmd_reg;
    logic [31:0] out_arg_reg;
    logic [3:0]  out_cls_reg;

    byte_event_t evt;
    cmd_info_t   info;
    logic        s_fire;
    logic [31:0] byte_placed;

    assign s_ready = !out_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign info    = cmd_lookup(s_data_byte);

    // place an address byte, most significant first
    always_comb begin
        case (addr_seen_reg[1:0])
            2'd0: byte_placed = {s_data_byte, 24'h0};
            2'd1: byte_placed = {8'h0, s_data_byte, 16'h0};
            2'd2: byte_placed = {16'h0, s_data_byte, 8'h0};
            2'd3: byte_placed = {24'h0, s_data_byte};
            default: byte_placed = '0;
        endcase
    end

    // next decoder state for the incoming byte
    always_comb begin
        pend_cmd_next   = pend_cmd_reg;
        ready_next      = ready_reg;
        addr_need_next  = addr_need_reg;
        addr_seen_next  = addr_seen_reg;
        dummy_need_next = dummy_need_reg;
        dummy_seen_next = dummy_seen_reg;
        arg_next        = arg_reg;
        cls_next        = cls_reg;
        evt             = EVT_EXTRA_BYTE;
        if (pend_cmd_reg == CMD_NONE || ready_reg) begin
            if (info.hit) begin
                pend_cmd_next   = s_data_byte;
                addr_need_next  = info.addr_bytes;
                dummy_need_next = info.dummy_bytes;
                cls_next        = info.cls;
                addr_seen_next  = '0;
                dummy_seen_next = '0;
                arg_next        = '0;
                ready_next      = 1'b0;
                evt             = EVT_CMD_ACCEPT;
            end else begin
                pend_cmd_next = CMD_NONE;
                evt           = EVT_CMD_UNKNOWN;
            end
        end else if (addr_seen_reg < addr_need_reg) begin
            arg_next       = arg_reg | byte_placed;
            addr_seen_next = addr_seen_reg + 3'd1;
            evt            = EVT_ADDR_BYTE;
        end else if (dummy_seen_reg < dummy_need_reg) begin
            dummy_seen_next = dummy_seen_reg + 3'd1;
            evt             = EVT_DUMMY_BYTE;
        end
        // command complete at transfer end
        if (s_ends_transfer && pend_cmd_next != CMD_NONE &&
            addr_seen_next == addr_need_next && dummy_seen_next == dummy_need_next) begin
            ready_next = 1'b1;
        end
    end

    // state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_cmd_reg   <= CMD_NONE;
            ready_reg      <= 1'b1;
            addr_need_reg  <= '0;
            addr_seen_reg  <= '0;
            dummy_need_reg <= '0;
            dummy_seen_reg <= '0;
            arg_reg        <= '0;
            cls_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (s_fire) begin
                pend_cmd_reg   <= pend_cmd_next;
                ready_reg      <= ready_next;
                addr_need_reg  <= addr_need_next;
                addr_seen_reg  <= addr_seen_next;
                dummy_need_reg <= dummy_need_next;
                dummy_seen_reg <= dummy_seen_next;
                arg_reg        <= arg_next;
                cls_reg        <= cls_next;
                out_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            out_event_reg <= evt;
            out_ready_reg <= ready_next;
            out_cmd_reg   <= pend_cmd_next;
            out_arg_reg   <= arg_next;
            out_cls_reg   <= cls_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_byte_event       = out_event_reg;
    assign m_command_ready    = out_ready_reg;
    assign m_command_code     = out_cmd_reg;
    assign m_command_argument = out_arg_reg;
    assign m_card_offset      = fold_offset(out_arg_reg);
    assign m_extra_area_flag  = out_arg_reg[7];
    assign m_execution_class  = out_cls_reg;

endmodule

>>> sv/mccp_checker.sv
// mccp_checker: port-level assertions for the command parser, bound to the top level
module mccp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_byte_event,
    input logic [7:0]  m_command_code,
    input logic [31:0] m_command_argument,
    input logic [23:0] m_card_offset,
    input logic        m_extra_area_flag
);
    import mccp_pkg::*;

    // a stalled result transaction stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // an unknown byte leaves no command pending
    a_unknown: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_event == EVT_CMD_UNKNOWN |-> m_command_code == CMD_NONE)
        else $error("unknown command left a code pending");

    // a newly accepted command starts with a clear argument
    a_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_event == EVT_CMD_ACCEPT |->
            m_command_argument == 32'h0 && m_command_code != CMD_NONE)
        else $error("accepted command with stale argument");

    // offset and extra-area flag follow the argument
    a_fold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_card_offset == fold_offset(m_command_argument) &&
            m_extra_area_flag == m_command_argument[7])
        else $error("offset fold mismatch");

endmodule

bind memory_card_command_parser_core mccp_checker u_mccp_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_byte_event       (m_byte_event),
    .m_command_code     (m_command_code),
    .m_command_argument (m_command_argument),
    .m_card_offset      (m_card_offset),
    .m_extra_area_flag  (m_extra_area_flag)
);

>>> bench/tb_memory_card_command_parser_core.sv
// testbench for the memory card command parser core: queued byte driver, result monitor
`timescale 1ns / 1ps

module tb_memory_card_command_parser_core;
    import mccp_pkg::*;

    // command bytes understood by the card
    localparam logic [7:0] OP_READ_ID       = 8'h00;
    localparam logic [7:0] OP_ARRAY_READ    = 8'h52;
    localparam logic [7:0] OP_SET_INTERRUPT = 8'h81;
    localparam logic [7:0] OP_READ_STATUS   = 8'h83;
    localparam logic [7:0] OP_READ_ID_ALT   = 8'h85;
    localparam logic [7:0] OP_SLEEP         = 8'h87;
    localparam logic [7:0] OP_WAKE_UP       = 8'h88;
    localparam logic [7:0] OP_CLEAR_STATUS  = 8'h89;
    localparam logic [7:0] OP_SECTOR_ERASE  = 8'hF1;
    localparam logic [7:0] OP_PAGE_PROGRAM  = 8'hF2;
    localparam logic [7:0] OP_CARD_ERASE    = 8'hF4;

    // execution class bits
    localparam logic [3:0] CLS_IMM_READ  = 4'h1;
    localparam logic [3:0] CLS_IMM_WRITE = 4'h2;
    localparam logic [3:0] CLS_DMA_READ  = 4'h4;
    localparam logic [3:0] CLS_DMA_WRITE = 4'h8;

    // run shape
    localparam int NUM_BYTES   = 900;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_AT    = 450;
    localparam int FAST_AT     = 600;
    localparam int FAST_LEN    = 100;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 10;

    typedef struct packed {
        logic       hit;
        logic [2:0] addr_n;
        logic [2:0] dummy_n;
        logic [3:0] cls;
    } op_entry_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [7:0] gap;
        logic       drain;
    } host_byte_t;

    typedef struct packed {
        byte_event_t ev;
        logic        rdy;
        logic [7:0]  code;
        logic [31:0] arg;
        logic [23:0] ofs;
        logic        xa;
        logic [3:0]  cls;
    } card_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'd0;
    logic        s_ends_transfer = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_byte_event;
    logic        m_command_ready;
    logic [7:0]  m_command_code;
    logic [31:0] m_command_argument;
    logic [23:0] m_card_offset;
    logic        m_extra_area_flag;
    logic [3:0]  m_execution_class;

    memory_card_command_parser_core uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_ends_transfer    (s_ends_transfer),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_byte_event       (m_byte_event),
        .m_command_ready    (m_command_ready),
        .m_command_code     (m_command_code),
        .m_command_argument (m_command_argument),
        .m_card_offset      (m_card_offset),
        .m_extra_area_flag  (m_extra_area_flag),
        .m_execution_class  (m_execution_class)
    );

    always #1 aclk = ~aclk;

    // decoder state as the bench sees it
    logic [7:0]  cur_cmd = CMD_NONE;
    logic        cmd_ready = 1'b1;
    logic [2:0]  addr_need = 3'd0;
    logic [2:0]  addr_got = 3'd0;
    logic [2:0]  dummy_need = 3'd0;
    logic [2:0]  dummy_got = 3'd0;
    logic [31:0] arg_word = 32'd0;
    logic [3:0]  exec_cls = 4'd0;

    host_byte_t   byte_q[$];
    card_result_t result_q[$];
    host_byte_t   head;
    card_result_t want;
    card_result_t seen;

    int bytes_sent = 0;
    int results_seen = 0;
    int errors = 0;
    int total_bytes = 0;
    int ready_count = 0;
    int evt_tally [0:4] = '{0, 0, 0, 0, 0};
    int stall_left = 0;
    int hold_left = 0;
    bit held_once = 1'b0;
    int idle_cycles = 0;

    // command table: hit, address bytes, dummy bytes, class
    function automatic op_entry_t op_lookup(input logic [7:0] code);
        op_entry_t e;
        e = '0;
        case (code)
            OP_READ_STATUS:   e = '{1'b1, 3'd0, 3'd1, CLS_IMM_READ};
            OP_CLEAR_STATUS:  e = '{1'b1, 3'd0, 3'd0, CLS_IMM_WRITE};
            OP_PAGE_PROGRAM:  e = '{1'b1, 3'd4, 3'd0, CLS_DMA_WRITE};
            OP_ARRAY_READ:    e = '{1'b1, 3'd4, 3'd4, CLS_DMA_READ | CLS_IMM_READ};
            OP_SECTOR_ERASE:  e = '{1'b1, 3'd2, 3'd0, CLS_IMM_WRITE};
            OP_READ_ID:       e = '{1'b1, 3'd0, 3'd1, CLS_IMM_READ};
            OP_CARD_ERASE:    e = '{1'b1, 3'd0, 3'd0, CLS_IMM_WRITE};
            OP_SET_INTERRUPT: e = '{1'b1, 3'd1, 3'd0, CLS_IMM_WRITE};
            OP_READ_ID_ALT:   e = '{1'b1, 3'd0, 3'd1, CLS_IMM_READ};
            OP_WAKE_UP:       e = '{1'b1, 3'd0, 3'd0, CLS_IMM_WRITE};
            OP_SLEEP:         e = '{1'b1, 3'd0, 3'd0, CLS_IMM_WRITE};
            default:          e = '0;
        endcase
        return e;
    endfunction

    // advance the decoder state by one host byte and form its result
    task automatic decode_byte(input logic [7:0] data, input logic last,
                               output card_result_t r);
        op_entry_t   e;
        byte_event_t ev;
        int          sh;
        logic [31:0] folded;
        if (cur_cmd == CMD_NONE || cmd_ready) begin
            e = op_lookup(data);
            ev = EVT_CMD_UNKNOWN;
            cur_cmd = CMD_NONE;
            if (e.hit) begin
                cur_cmd = data;
                addr_need = e.addr_n;
                dummy_need = e.dummy_n;
                exec_cls = e.cls;
                addr_got = 3'd0;
                dummy_got = 3'd0;
                arg_word = 32'd0;
                cmd_ready = 1'b0;
                ev = EVT_CMD_ACCEPT;
            end
        end else if (addr_got < addr_need) begin
            sh = 24 - 8 * int'(addr_got[1:0]);
            arg_word = arg_word | (32'(data) << sh);
            addr_got = addr_got + 3'd1;
            ev = EVT_ADDR_BYTE;
        end else if (dummy_got < dummy_need) begin
            dummy_got = dummy_got + 3'd1;
            ev = EVT_DUMMY_BYTE;
        end else begin
            ev = EVT_EXTRA_BYTE;
        end
        // transfer end completes a command only once all its bytes are in
        if (last && cur_cmd != CMD_NONE && addr_got == addr_need && dummy_got == dummy_need) begin
            if (!cmd_ready) ready_count++;
            cmd_ready = 1'b1;
        end
        folded = (arg_word & OFS_BYTE_MASK) | ((arg_word & OFS_PAGE_MASK) >> 1)
               | ((arg_word & OFS_SECT_MASK) >> 7);
        evt_tally[int'(ev)]++;
        r.ev = ev;
        r.rdy = cmd_ready;
        r.code = cur_cmd;
        r.arg = arg_word;
        r.ofs = folded[23:0];
        r.xa = arg_word[7];
        r.cls = exec_cls;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t ns: result %0d field %s expected 0x%0h, got 0x%0h",
                     $time, results_seen, name, exp_val, act_val);
            errors++;
        end
    endtask

    // mostly back to back, some short gaps, a few long ones
    function automatic logic [7:0] pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 8'd0;
        else if (r < 92) return 8'($urandom_range(1, 3));
        else return 8'($urandom_range(8, 25));
    endfunction

    task automatic add_byte(input logic [7:0] data, input logic last);
        host_byte_t b;
        int idx;
        idx = byte_q.size();
        b.data = data;
        b.last = last;
        b.gap = pick_gap();
        b.drain = (idx == DRAIN_AT) || ($urandom_range(0, 149) == 0);
        // keep the sender busy across the receiver hold-off and the fast stretch
        if ((idx >= HOLD_AT && idx < HOLD_AT + 80) || (idx >= FAST_AT && idx < FAST_AT + FAST_LEN))
            b.gap = 8'd0;
        byte_q.push_back(b);
    endtask

    function automatic logic [7:0] pick_op();
        logic [7:0] code;
        op_entry_t e;
        e = '0;
        code = 8'd0;
        while (!e.hit) begin
            code = 8'($urandom_range(0, 255));
            e = op_lookup(code);
        end
        return code;
    endfunction

    // one command sequence: mostly well formed, some truncated, overrun or noise
    task automatic add_sequence();
        int mode;
        int n;
        int k;
        int extra;
        logic [7:0] code;
        op_entry_t e;
        mode = $urandom_range(0, 9);
        code = pick_op();
        e = op_lookup(code);
        n = int'(e.addr_n) + int'(e.dummy_n);
        if (mode <= 6) begin
            add_byte(code, n == 0);
            for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)), i == n - 1);
        end else if (mode == 7) begin
            // transfer ends before all bytes are in, where the command has any to send
            k = (n == 0) ? 0 : $urandom_range(0, n - 1);
            add_byte(code, k == 0);
            for (int i = 0; i < k; i++) add_byte(8'($urandom_range(0, 255)), i == k - 1);
        end else if (mode == 8) begin
            // bytes beyond the command, transfer ends on the last of them
            extra = $urandom_range(1, 3);
            add_byte(code, 1'b0);
            for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)), 1'b0);
            for (int i = 0; i < extra; i++) add_byte(8'($urandom_range(0, 255)), i == extra - 1);
        end else begin
            extra = $urandom_range(1, 4);
            for (int i = 0; i < extra; i++)
                add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endtask

    // sender: presents queued bytes, predicts each accepted transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(s_data_byte, s_ends_transfer, want);
                result_q.push_back(want);
                bytes_sent++;
            end
            if (!s_valid || s_ready) begin
                if (byte_q.size() == 0) begin
                    s_valid <= 1'b0;
                end else begin
                    head = byte_q[0];
                    if (head.gap != 8'd0) begin
                        head.gap = head.gap - 8'd1;
                        byte_q[0] = head;
                        s_valid <= 1'b0;
                    end else if (head.drain && result_q.size() != 0) begin
                        s_valid <= 1'b0;
                    end else begin
                        void'(byte_q.pop_front());
                        s_valid <= 1'b1;
                        s_data_byte <= head.data;
                        s_ends_transfer <= head.last;
                    end
                end
            end
        end
    end

    // receiver: checks each result transaction and throttles m_ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                seen.ev = byte_event_t'(m_byte_event);
                seen.rdy = m_command_ready;
                seen.code = m_command_code;
                seen.arg = m_command_argument;
                seen.ofs = m_card_offset;
                seen.xa = m_extra_area_flag;
                seen.cls = m_execution_class;
                if (result_q.size() == 0) begin
                    $display("%0t ns: result with no byte outstanding, expected none, got event %0d",
                             $time, m_byte_event);
                    errors++;
                end else begin
                    want = result_q.pop_front();
                    check_field("byte_event", 32'(want.ev), 32'(seen.ev));
                    check_field("command_ready", 32'(want.rdy), 32'(seen.rdy));
                    check_field("command_code", 32'(want.code), 32'(seen.code));
                    check_field("command_argument", want.arg, seen.arg);
                    check_field("card_offset", 32'(want.ofs), 32'(seen.ofs));
                    check_field("extra_area_flag", 32'(want.xa), 32'(seen.xa));
                    check_field("execution_class", 32'(want.cls), 32'(seen.cls));
                    results_seen++;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!held_once && bytes_sent >= HOLD_AT) begin
                // long hold-off so the block backs up onto its input
                held_once = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (bytes_sent >= FAST_AT && bytes_sent < FAST_AT + FAST_LEN) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                case ($urandom_range(0, 19))
                    0, 1, 2: stall_left = $urandom_range(0, 2);
                    3:       stall_left = $urandom_range(8, 25);
                    default: stall_left = -1;
                endcase
                m_ready <= (stall_left < 0);
                if (stall_left < 0) stall_left = 0;
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t ns: no transaction for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, result_q.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        // directed: unknown byte at reset with transfer end and no command
        add_byte(8'hFF, 1'b1);
        // array read with all-ones address, transfer ends one dummy short
        add_byte(OP_ARRAY_READ, 1'b0);
        for (int i = 0; i < 4; i++) add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b1);
        add_byte(8'h00, 1'b1);
        add_byte(OP_READ_ID, 1'b0);
        add_byte(8'h55, 1'b1);
        // bytes past the end of a command
        add_byte(OP_CLEAR_STATUS, 1'b0);
        add_byte(8'hAA, 1'b0);
        add_byte(8'h12, 1'b1);
        // program with the extra-area bit set
        add_byte(OP_PAGE_PROGRAM, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h80, 1'b1);
        // unknown byte after a ready command keeps the old argument
        add_byte(8'h13, 1'b0);
        add_byte(OP_SET_INTERRUPT, 1'b0);
        add_byte(8'h7F, 1'b1);
        add_byte(OP_READ_STATUS, 1'b0);
        add_byte(8'h01, 1'b1);
        add_byte(OP_SECTOR_ERASE, 1'b0);
        add_byte(8'hC3, 1'b0);
        add_byte(8'h3C, 1'b1);
        add_byte(OP_CARD_ERASE, 1'b1);
        add_byte(OP_READ_ID_ALT, 1'b0);
        add_byte(8'hFE, 1'b1);
        add_byte(OP_WAKE_UP, 1'b1);
        add_byte(OP_SLEEP, 1'b1);
        // random command sequences
        while (byte_q.size() < NUM_BYTES) add_sequence();
        total_bytes = byte_q.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (bytes_sent < total_bytes) @(posedge aclk);
        while (result_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("run covered %0d host bytes and %0d results, %0d commands completed",
                 bytes_sent, results_seen, ready_count);
        $display("events: accept %0d, unknown %0d, address %0d, dummy %0d, extra %0d",
                 evt_tally[0], evt_tally[1], evt_tally[2], evt_tally[3], evt_tally[4]);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> memory_card_command_parser_core.f
sv/mccp_pkg.sv
sv/memory_card_command_parser_core.sv
sv/mccp_checker.sv
bench/tb_memory_card_command_parser_core.sv
